FILE: hdl/ulb_pkg.sv
// shared constants, microcode word layout and datapath types for the underwater lowpass blend
package ulb_pkg;

  // coefficient fraction bits (valid range 12 to 24)
  localparam int COEF_FRAC_BITS = 16;
  localparam int FRAC           = COEF_FRAC_BITS;

  localparam int SAMPLE_W  = 16;
  localparam int LP_W      = 32;
  localparam int XQ_SHIFT  = 16;
  localparam int COEF_W    = FRAC + 1;
  localparam int MA_W      = LP_W + 1;
  localparam int MB_W      = COEF_W + 1;
  localparam int PROD_W    = MA_W + MB_W;
  localparam int ACC_W     = PROD_W + 1;
  localparam int SUM_W     = ACC_W - FRAC + 1;
  localparam int OUT_SH    = FRAC + XQ_SHIFT;
  localparam int Q_W       = ACC_W - OUT_SH;
  localparam int PC_W      = 4;

  localparam longint unsigned ONE_Q  = 64'd1 << FRAC;
  localparam longint unsigned K08_Q  = (64'd8 * ONE_Q + 64'd50) / 64'd100;
  localparam longint unsigned A10_Q  = (64'd10 * ONE_Q + 64'd50) / 64'd100;
  localparam longint unsigned A40_Q  = (64'd40 * ONE_Q + 64'd50) / 64'd100;
  localparam longint unsigned K35_Q  = (64'd35 * ONE_Q + 64'd50) / 64'd100;
  localparam longint unsigned TH_Q   = (64'd5 * ONE_Q) / 64'd1000;
  localparam longint unsigned BIAS_Q = (64'd1 << OUT_SH) - 64'd1;

  localparam logic [COEF_W-1:0] ONE_C  = COEF_W'(ONE_Q);
  localparam logic [COEF_W-1:0] HALF_C = COEF_W'(ONE_Q >> 1);
  localparam logic [COEF_W-1:0] K08_C  = COEF_W'(K08_Q);
  localparam logic [COEF_W-1:0] A10_C  = COEF_W'(A10_Q);
  localparam logic [COEF_W-1:0] A40_C  = COEF_W'(A40_Q);
  localparam logic [COEF_W-1:0] K35_C  = COEF_W'(K35_Q);
  localparam logic [FRAC-1:0]   MIX_TH_C = FRAC'(TH_Q);

  localparam logic signed [ACC_W-1:0] HALF_ACC   = ACC_W'(ONE_Q >> 1);
  localparam logic signed [ACC_W-1:0] TRUNC_BIAS = ACC_W'(BIAS_Q);

  localparam logic signed [SUM_W-1:0] LP_HI = SUM_W'({1'b0, {(LP_W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] LP_LO = ~LP_HI;
  localparam logic signed [LP_W-1:0]  LP_MAX = {1'b0, {(LP_W-1){1'b1}}};
  localparam logic signed [LP_W-1:0]  LP_MIN = ~LP_MAX;

  localparam logic signed [Q_W-1:0] Q_HI = Q_W'({1'b0, {(SAMPLE_W-1){1'b1}}});
  localparam logic signed [Q_W-1:0] Q_LO = ~Q_HI;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = ~SAMPLE_MAX;

  // microprogram addresses
  localparam logic [PC_W-1:0] PC_IDLE  = PC_W'(0);
  localparam logic [PC_W-1:0] PC_UPD   = PC_W'(1);
  localparam logic [PC_W-1:0] PC_MIXW  = PC_W'(2);
  localparam logic [PC_W-1:0] PC_ALPH  = PC_W'(3);
  localparam logic [PC_W-1:0] PC_ALPW  = PC_W'(4);
  localparam logic [PC_W-1:0] PC_GAINW = PC_W'(5);
  localparam logic [PC_W-1:0] PC_CHK   = PC_W'(6);
  localparam logic [PC_W-1:0] PC_FILT  = PC_W'(7);
  localparam logic [PC_W-1:0] PC_LPW   = PC_W'(8);
  localparam logic [PC_W-1:0] PC_BL2   = PC_W'(9);
  localparam logic [PC_W-1:0] PC_BLW   = PC_W'(10);
  localparam logic [PC_W-1:0] PC_OUTW  = PC_W'(11);
  localparam logic [PC_W-1:0] PC_DONE  = PC_W'(12);

  typedef enum logic [2:0] {
    A_MIXD, A_ONEM, A_MIX, A_DIFF, A_X, A_LP, A_BLEND
  } a_sel_t;

  typedef enum logic [2:0] {
    B_K08, B_A40, B_K35, B_ALPHA, B_ONEM, B_MIX, B_GAIN
  } b_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_LOAD_SH, ACC_ADD
  } acc_op_t;

  typedef enum logic [2:0] {
    WB_NONE, WB_MIX, WB_ALPHA, WB_GAIN, WB_LP, WB_OUT, WB_ACT
  } wb_t;

  typedef enum logic [2:0] {
    J_NEXT, J_ALWAYS, J_NOUPD, J_NOACT, J_CHAN, J_WAIT_IN, J_WAIT_OUT
  } jump_t;

  typedef struct packed {
    logic            take_in;
    logic            emit;
    a_sel_t          a_sel;
    b_sel_t          b_sel;
    acc_op_t         acc_op;
    logic            rnd;
    wb_t             wb;
    jump_t           jump;
    logic [PC_W-1:0] target;
  } cw_t;

  localparam cw_t CW_NOP = '{
    take_in: 1'b0, emit: 1'b0, a_sel: A_MIX, b_sel: B_MIX, acc_op: ACC_HOLD,
    rnd: 1'b0, wb: WB_NONE, jump: J_NEXT, target: PC_IDLE
  };

  typedef struct packed {
    logic upd;
    logic act;
    logic chan_more;
  } flags_t;

  typedef struct packed {
    logic                       act;
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } result_t;

endpackage

FILE: hdl/ulb_ucode_rom.sv
// microprogram table: one control word per step address
module ulb_ucode_rom
  import ulb_pkg::*;
(
  input  logic [PC_W-1:0] pc,
  output cw_t             cw
);

  always_comb begin
    cw = CW_NOP;
    case (pc)
      PC_IDLE: begin
        cw.take_in = 1'b1;
        cw.jump    = J_WAIT_IN;
      end
      PC_UPD: begin
        // step size of the mix toward its target
        cw.a_sel  = A_MIXD;
        cw.b_sel  = B_K08;
        cw.acc_op = ACC_LOAD;
        cw.rnd    = 1'b1;
        cw.jump   = J_NOUPD;
        cw.target = PC_CHK;
      end
      PC_MIXW: begin
        cw.wb = WB_MIX;
      end
      PC_ALPH: begin
        cw.a_sel  = A_ONEM;
        cw.b_sel  = B_A40;
        cw.acc_op = ACC_LOAD;
        cw.rnd    = 1'b1;
      end
      PC_ALPW: begin
        cw.wb     = WB_ALPHA;
        cw.a_sel  = A_MIX;
        cw.b_sel  = B_K35;
        cw.acc_op = ACC_LOAD;
        cw.rnd    = 1'b1;
      end
      PC_GAINW: begin
        cw.wb = WB_GAIN;
      end
      PC_CHK: begin
        cw.wb     = WB_ACT;
        cw.jump   = J_NOACT;
        cw.target = PC_DONE;
      end
      PC_FILT: begin
        cw.a_sel  = A_DIFF;
        cw.b_sel  = B_ALPHA;
        cw.acc_op = ACC_LOAD;
        cw.rnd    = 1'b1;
      end
      PC_LPW: begin
        cw.wb     = WB_LP;
        cw.a_sel  = A_X;
        cw.b_sel  = B_ONEM;
        cw.acc_op = ACC_LOAD_SH;
        cw.rnd    = 1'b1;
      end
      PC_BL2: begin
        cw.a_sel  = A_LP;
        cw.b_sel  = B_MIX;
        cw.acc_op = ACC_ADD;
      end
      PC_BLW: begin
        cw.a_sel  = A_BLEND;
        cw.b_sel  = B_GAIN;
        cw.acc_op = ACC_LOAD;
      end
      PC_OUTW: begin
        cw.wb     = WB_OUT;
        cw.jump   = J_CHAN;
        cw.target = PC_FILT;
      end
      PC_DONE: begin
        cw.emit   = 1'b1;
        cw.jump   = J_WAIT_OUT;
        cw.target = PC_IDLE;
      end
      default: begin
        cw.jump   = J_ALWAYS;
        cw.target = PC_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/ulb_sequencer.sv
// step counter with conditional jumps over the microprogram
module ulb_sequencer
  import ulb_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   frame_fire,
  input  logic   slot_free,
  input  flags_t flags,
  output cw_t    cw
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic [PC_W-1:0] pc_inc;

  ulb_ucode_rom u_rom (
    .pc (pc),
    .cw (cw)
  );

  assign pc_inc = pc + 1'b1;

  always_comb begin
    case (cw.jump)
      J_NEXT:     pc_next = pc_inc;
      J_ALWAYS:   pc_next = cw.target;
      J_NOUPD:    pc_next = flags.upd ? pc_inc : cw.target;
      J_NOACT:    pc_next = flags.act ? pc_inc : cw.target;
      J_CHAN:     pc_next = flags.chan_more ? cw.target : pc_inc;
      J_WAIT_IN:  pc_next = frame_fire ? pc_inc : pc;
      J_WAIT_OUT: pc_next = slot_free ? cw.target : pc;
      default:    pc_next = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

FILE: hdl/ulb_datapath.sv
// shared multiply-accumulate datapath with mix, coefficient and lowpass state
module ulb_datapath
  import ulb_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  cw_t                        cw,
  input  logic                       frame_fire,
  input  logic                       buffer_start,
  input  logic                       player_present,
  input  logic                       underwater,
  input  logic signed [SAMPLE_W-1:0] sample_left,
  input  logic signed [SAMPLE_W-1:0] sample_right,
  input  logic                       stereo_mode,
  output flags_t                     flags,
  output result_t                    res
);

  logic [FRAC-1:0]   mix;
  logic [COEF_W-1:0] alpha;
  logic [COEF_W-1:0] gain;
  logic signed [LP_W-1:0] lp_l;
  logic signed [LP_W-1:0] lp_r;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_next;
  logic ch;
  logic start_r;
  logic present_r;
  logic under_r;
  logic signed [SAMPLE_W-1:0] x_l;
  logic signed [SAMPLE_W-1:0] x_r;

  logic [COEF_W-1:0]          onem;
  logic signed [SAMPLE_W-1:0] x_cur;
  logic signed [LP_W-1:0]     lp_cur;
  logic signed [LP_W-1:0]     xq;
  logic signed [MA_W-1:0]     op_a;
  logic signed [MB_W-1:0]     op_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    prod_ext;
  logic signed [ACC_W-1:0]    rnd_v;
  logic signed [ACC_W-1:0]    acc_shr;
  logic signed [SUM_W-1:0]    lp_sum;
  logic signed [LP_W-1:0]     lp_sat;
  logic signed [ACC_W-1:0]    out_full;
  logic signed [Q_W-1:0]      q;
  logic signed [SAMPLE_W-1:0] q_sat;

  assign onem   = ONE_C - {1'b0, mix};
  assign x_cur  = ch ? x_r : x_l;
  assign lp_cur = ch ? lp_r : lp_l;
  assign xq     = {x_cur, {XQ_SHIFT{1'b0}}};
  assign acc_shr = acc >>> FRAC;

  always_comb begin
    case (cw.a_sel)
      A_MIXD:  op_a = under_r ? MA_W'(onem) : MA_W'(mix);
      A_ONEM:  op_a = MA_W'(onem);
      A_MIX:   op_a = MA_W'(mix);
      A_DIFF:  op_a = MA_W'(xq) - MA_W'(lp_cur);
      A_X:     op_a = MA_W'(x_cur);
      A_LP:    op_a = MA_W'(lp_cur);
      A_BLEND: op_a = MA_W'(acc_shr);
      default: op_a = '0;
    endcase
  end

  always_comb begin
    case (cw.b_sel)
      B_K08:   op_b = {1'b0, K08_C};
      B_A40:   op_b = {1'b0, A40_C};
      B_K35:   op_b = {1'b0, K35_C};
      B_ALPHA: op_b = {1'b0, alpha};
      B_ONEM:  op_b = {1'b0, onem};
      B_MIX:   op_b = {2'b00, mix};
      B_GAIN:  op_b = {1'b0, gain};
      default: op_b = '0;
    endcase
  end

  assign prod     = op_a * op_b;
  assign prod_ext = ACC_W'(prod);
  assign rnd_v    = cw.rnd ? HALF_ACC : '0;

  always_comb begin
    case (cw.acc_op)
      ACC_HOLD:    acc_next = acc;
      ACC_LOAD:    acc_next = prod_ext + rnd_v;
      ACC_LOAD_SH: acc_next = (prod_ext <<< XQ_SHIFT) + rnd_v;
      ACC_ADD:     acc_next = acc + prod_ext + rnd_v;
      default:     acc_next = acc;
    endcase
  end

  // lowpass update with saturation to the state width
  assign lp_sum = SUM_W'(lp_cur) + SUM_W'(acc_shr);
  assign lp_sat = (lp_sum > LP_HI) ? LP_MAX :
                  (lp_sum < LP_LO) ? LP_MIN : LP_W'(lp_sum);

  // output: truncate toward zero then clamp to a sample
  assign out_full = (acc + (acc[ACC_W-1] ? TRUNC_BIAS : '0)) >>> OUT_SH;
  assign q        = Q_W'(out_full);
  assign q_sat    = (q > Q_HI) ? SAMPLE_MAX :
                    (q < Q_LO) ? SAMPLE_MIN : SAMPLE_W'(q);

  assign flags.upd       = start_r & present_r;
  assign flags.act       = present_r & (mix > MIX_TH_C);
  assign flags.chan_more = ~ch & stereo_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      mix   <= '0;
      alpha <= HALF_C;
      gain  <= ONE_C;
      lp_l  <= '0;
      lp_r  <= '0;
      ch    <= 1'b0;
    end else begin
      acc <= acc_next;
      if (frame_fire) begin
        start_r   <= buffer_start;
        present_r <= player_present;
        under_r   <= underwater;
        x_l       <= sample_left;
        x_r       <= sample_right;
        res.left  <= sample_left;
        res.right <= sample_right;
        res.act   <= 1'b0;
        ch        <= 1'b0;
      end
      case (cw.wb)
        WB_NONE: ;
        WB_MIX: begin
          mix <= under_r ? mix + acc_shr[FRAC-1:0] : mix - acc_shr[FRAC-1:0];
        end
        WB_ALPHA: alpha <= A10_C + acc_shr[COEF_W-1:0];
        WB_GAIN:  gain  <= ONE_C - acc_shr[COEF_W-1:0];
        WB_LP: begin
          if (ch) begin
            lp_r <= lp_sat;
          end else begin
            lp_l <= lp_sat;
          end
        end
        WB_OUT: begin
          if (ch) begin
            res.right <= q_sat;
          end else begin
            res.left <= q_sat;
          end
          ch <= 1'b1;
        end
        WB_ACT: res.act <= flags.act;
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/underwater_lowpass_blend.sv
// top level of the underwater lowpass blend: sequencer, datapath and output register
// one frame at a time: a frame is taken only in the idle step, once the last result
//   is loaded; a mix update runs only on a buffer start with a player present, and
//   filtering (per channel in stereo) only with the filter active; the single shared
//   multiplier does at most one product per cycle, none in the wait steps
// reset (synchronous, rst high): sequencer idle, mix 0, alpha one half, gain one,
//   lowpass states zero, stereo mode on, no result pending
module underwater_lowpass_blend
  import ulb_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  // frame channel
  input  logic                       frame_valid,
  output logic                       frame_stall,
  input  logic                       buffer_start,
  input  logic                       player_present,
  input  logic                       underwater,
  input  logic signed [SAMPLE_W-1:0] sample_left,
  input  logic signed [SAMPLE_W-1:0] sample_right,
  // result channel
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic signed [SAMPLE_W-1:0] out_left,
  output logic signed [SAMPLE_W-1:0] out_right,
  output logic                       filter_active,
  // stereo mode register
  input  logic                       cfg_we,
  input  logic                       cfg_wdata
);

  cw_t     cw;
  flags_t  flags;
  result_t res;
  logic    stereo_mode;
  logic    frame_fire;
  logic    slot_free;
  logic    out_load;

  // a frame is only taken while the program sits in its idle step
  assign frame_stall = ~cw.take_in;
  assign frame_fire  = frame_valid & cw.take_in;

  // the output register frees up when empty or when its beat is taken this cycle
  assign slot_free = ~result_valid | ~result_stall;
  assign out_load  = cw.emit & slot_free;

  ulb_sequencer u_seq (
    .clk        (clk),
    .rst        (rst),
    .frame_fire (frame_fire),
    .slot_free  (slot_free),
    .flags      (flags),
    .cw         (cw)
  );

  ulb_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cw             (cw),
    .frame_fire     (frame_fire),
    .buffer_start   (buffer_start),
    .player_present (player_present),
    .underwater     (underwater),
    .sample_left    (sample_left),
    .sample_right   (sample_right),
    .stereo_mode    (stereo_mode),
    .flags          (flags),
    .res            (res)
  );

  // configuration register, to be written only while no frame is in flight; not checked
  always_ff @(posedge clk) begin
    if (rst) begin
      stereo_mode <= 1'b1;
    end else if (cfg_we) begin
      stereo_mode <= cfg_wdata;
    end
  end

  // output register: holds a finished beat so the next frame can start
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (~result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_left      <= res.left;
      out_right     <= res.right;
      filter_active <= res.act;
    end
  end

endmodule

FILE: hdl/ulb_checker.sv
// port-level checks for the underwater lowpass blend, bound to the top level
module ulb_checker
  import ulb_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       frame_valid,
  input logic                       frame_stall,
  input logic                       result_valid,
  input logic                       result_stall,
  input logic signed [SAMPLE_W-1:0] out_left,
  input logic signed [SAMPLE_W-1:0] out_right,
  input logic                       filter_active
);

  // a stalled result beat stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      $stable(out_left) && $stable(out_right) && $stable(filter_active))
    else $error("result payload changed while stalled");

  // one frame at a time: after a frame is taken the input is stalled
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    frame_valid && !frame_stall |=> frame_stall)
    else $error("second frame taken while one is in flight");

  // after reset nothing is pending and the block is ready for a frame
  a_reset_state: assert property (@(posedge clk)
    rst |=> !result_valid && !frame_stall)
    else $error("wrong state after reset");

endmodule

bind underwater_lowpass_blend ulb_checker u_ulb_checker (.*);
